// File: rtl/core/histogram_auto_levels_assert.svh
// Assertion macros used by the checker file hal_checker.
`ifndef HISTOGRAM_AUTO_LEVELS_ASSERT_SVH
`define HISTOGRAM_AUTO_LEVELS_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define HAL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define HAL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/hal_pkg.sv
package hal_pkg;

    localparam int NUM_BINS   = 256;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACK_LIMIT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WHITE_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_GAIN = 3'd5;

    // 255.0 in Q8.16.
    localparam logic [23:0] Q_MAX = 24'hFF0000;
    localparam logic [23:0] Q_HALF = 24'h008000;

    // ceil(2^35 / 25): x * RECIP_25 >> 35 equals floor(x / 25) for any
    // x below 2^30, so floor(n / 100) is taken as floor((n >> 2) / 25).
    localparam logic [30:0] RECIP_25 = 31'd1374389535;
    localparam int          RECIP_SHIFT = 35;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PIX_RD,
        OP_PIX_WR,
        OP_FE_OUT,
        OP_DIV_INIT,
        OP_WALK,
        OP_WALK_LAST,
        OP_MUL,
        OP_ADD,
        OP_LEVEL,
        OP_RDIV_INIT,
        OP_RDIV_STEP,
        OP_BUILD
    } hal_op_t;

    typedef struct packed {
        hal_op_t    op;
        logic [7:0] idx;
        logic       sel_white;
        logic       out_load;
        logic       upd;
        logic       reb;
    } hal_cmd_t;

    typedef struct packed {
        logic out_free;
        logic enough;
        logic changed;
    } hal_sts_t;

    // Grey level to RGB565 with the two bytes swapped.
    function automatic logic [15:0] grey_colour(input logic [7:0] g);
        logic [15:0] c;
        c = {g[7:3], g[7:2], g[7:3]};
        return {c[7:0], c[15:8]};
    endfunction

endpackage

// File: rtl/core/hal_ram.sv
module hal_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/hal_datapath.sv
module hal_datapath #(
    parameter int BIN_BITS   = 16,
    parameter int TOTAL_BITS = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [hal_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [hal_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [7:0]                      s_pixel,
    input  logic                            s_counted,
    input  hal_pkg::hal_cmd_t               cmd,
    output hal_pkg::hal_sts_t               sts,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [15:0]                     m_colour,
    output logic [7:0]                      m_black_point,
    output logic [7:0]                      m_white_point,
    output logic                            m_levels_updated,
    output logic                            m_table_rebuilt
);
    import hal_pkg::*;

    localparam int ACC_W = (BIN_BITS + 8 > TOTAL_BITS) ? BIN_BITS + 8 : TOTAL_BITS;
    localparam int CMP_W = (TOTAL_BITS > CFG_DATA_W) ? TOTAL_BITS : CFG_DATA_W;
    localparam logic [BIN_BITS-1:0]   BIN_MAX   = {BIN_BITS{1'b1}};
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    // Configuration.
    logic        auto_en_reg;
    logic [19:0] min_samples_reg;
    logic [7:0]  black_limit_reg, white_floor_reg, min_span_reg;
    logic [15:0] gain_reg;

    // Control state.
    logic [TOTAL_BITS-1:0] total_reg;
    logic [23:0]           sb_reg, sw_reg;
    logic [7:0]            tblack_reg, twhite_reg;
    logic                  tbl_written_reg;
    logic [NUM_BINS-1:0]   hvld_reg;
    logic                  hvld_q_reg;
    logic                  walk_pend_reg;
    logic                  m_valid_reg;

    // Payload state.
    logic [7:0]            pix_reg;
    logic                  counted_reg;
    logic [TOTAL_BITS-1:0] quo_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [7:0]            walk_idx_reg, black_reg, white_reg;
    logic signed [42:0]    prod_reg;
    logic [7:0]            bnew_reg, wnew_reg;
    logic [7:0]            rdvd_reg, qd_reg, rrem_reg;
    logic [15:0]           qacc_reg;
    logic [7:0]            racc_reg;
    logic [15:0]           m_colour_reg;
    logic [7:0]            m_black_reg, m_white_reg;
    logic                  m_upd_reg, m_reb_reg;

    // Memories.
    logic                hist_we, hist_re, tbl_we, tbl_re;
    logic [7:0]          hist_raddr;
    logic [BIN_BITS-1:0] hist_wdata, hist_rdata;
    logic [15:0]         tbl_wdata, tbl_rdata;

    hal_ram #(.WIDTH(BIN_BITS), .DEPTH(NUM_BINS)) u_hist (
        .clk(aclk), .we(hist_we), .waddr(pix_reg), .wdata(hist_wdata),
        .re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
    );

    hal_ram #(.WIDTH(16), .DEPTH(NUM_BINS)) u_tbl (
        .clk(aclk), .we(tbl_we), .waddr(cmd.idx), .wdata(tbl_wdata),
        .re(tbl_re), .raddr(s_pixel), .rdata(tbl_rdata)
    );

    // Combinational datapath.
    logic [BIN_BITS-1:0]   bin_val;
    logic [TOTAL_BITS-1:0] lo_val, hi_val;
    logic [ACC_W-1:0]      acc_sum;
    logic [29:0]           quarter;
    logic [60:0]           pct_prod;
    logic [7:0]            level8;
    logic [23:0]           s_cur;
    logic signed [25:0]    diff;
    logic signed [42:0]    adj, sum43;
    logic [23:0]           s_new;
    logic [24:0]           sbr, swr;
    logic [7:0]            b8, w8, bnew8;
    logic signed [9:0]     span10, bt10;
    logic [7:0]            dd;
    logic [8:0]            rdiv_r2, rr;
    logic                  carry, degen;
    logic [15:0]           qn;
    logic [7:0]            grey_o;
    logic [15:0]           pix_colour;

    always_comb begin
        bin_val    = hvld_q_reg ? hist_rdata : '0;
        hist_wdata = (bin_val == BIN_MAX) ? bin_val : bin_val + 1'b1;
        hist_re    = (cmd.op == OP_PIX_RD) || (cmd.op == OP_WALK);
        hist_raddr = (cmd.op == OP_WALK) ? cmd.idx : s_pixel;
        hist_we    = (cmd.op == OP_PIX_WR) && counted_reg;
        tbl_re     = (cmd.op == OP_PIX_RD);

        // floor(total / 100) by a reciprocal multiply of total / 4.
        quarter  = 30'(total_reg >> 2);
        pct_prod = 61'(quarter) * 61'(RECIP_25);

        lo_val  = quo_reg;
        hi_val  = total_reg - (quo_reg >> 1);
        acc_sum = acc_reg + ACC_W'(bin_val);

        if (cmd.sel_white) begin
            level8 = (white_reg < white_floor_reg) ? white_floor_reg : white_reg;
            s_cur  = sw_reg;
        end else begin
            level8 = (black_reg > black_limit_reg) ? black_limit_reg : black_reg;
            s_cur  = sb_reg;
        end
        diff  = $signed({2'b00, level8, 16'h0000}) - $signed({2'b00, s_cur});
        adj   = (prod_reg + 43'sd32768) >>> 16;
        sum43 = $signed({19'd0, s_cur}) + adj;
        if (sum43 < 0) begin
            s_new = '0;
        end else if (sum43 > $signed({19'd0, Q_MAX})) begin
            s_new = Q_MAX;
        end else begin
            s_new = sum43[23:0];
        end

        sbr    = {1'b0, sb_reg} + {1'b0, Q_HALF};
        swr    = {1'b0, sw_reg} + {1'b0, Q_HALF};
        b8     = sbr[23:16];
        w8     = swr[23:16];
        span10 = $signed({2'b00, w8}) - $signed({2'b00, b8});
        bt10   = $signed({2'b00, w8}) - $signed({2'b00, min_span_reg});
        if (span10 < $signed({2'b00, min_span_reg})) begin
            bnew8 = (bt10 < 0) ? 8'd0 : bt10[7:0];
        end else begin
            bnew8 = b8;
        end

        // Table rebuild: the quotient of (v - b) * 255 / (w - b) advances by
        // 255 / (w - b) per entry with a remainder carry.
        dd      = wnew_reg - bnew_reg;
        degen   = (wnew_reg <= bnew_reg);
        rdiv_r2 = {rrem_reg, rdvd_reg[7]};
        rr      = {1'b0, racc_reg} + {1'b0, rrem_reg};
        carry   = (rr >= {1'b0, dd});
        qn      = qacc_reg + {8'd0, qd_reg} + {15'd0, carry};
        if (degen) begin
            grey_o = (cmd.idx < bnew_reg) ? 8'd0 : 8'd255;
        end else if (cmd.idx <= bnew_reg) begin
            grey_o = 8'd0;
        end else begin
            grey_o = (qn > 16'd255) ? 8'd255 : qn[7:0];
        end
        tbl_wdata = grey_colour(grey_o);
        tbl_we    = (cmd.op == OP_BUILD);

        pix_colour = tbl_written_reg ? tbl_rdata : grey_colour(pix_reg);

        sts.out_free = !m_valid_reg || m_ready;
        sts.enough   = auto_en_reg && (CMP_W'(total_reg) >= CMP_W'(min_samples_reg));
        sts.changed  = (bnew_reg != tblack_reg) || (wnew_reg != twhite_reg);
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_en_reg     <= 1'b1;
            min_samples_reg <= 20'd2000;
            black_limit_reg <= 8'd48;
            white_floor_reg <= 8'd160;
            min_span_reg    <= 8'd160;
            gain_reg        <= 16'd9830;
            total_reg       <= '0;
            sb_reg          <= '0;
            sw_reg          <= Q_MAX;
            tblack_reg      <= 8'd0;
            twhite_reg      <= 8'd255;
            tbl_written_reg <= 1'b0;
            hvld_reg        <= '0;
            walk_pend_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_AUTO_ENABLE:    auto_en_reg     <= cfg_data[0];
                    CFG_MIN_SAMPLES:    min_samples_reg <= cfg_data;
                    CFG_BLACK_LIMIT:    black_limit_reg <= cfg_data[7:0];
                    CFG_WHITE_FLOOR:    white_floor_reg <= cfg_data[7:0];
                    CFG_MIN_SPAN:       min_span_reg    <= cfg_data[7:0];
                    CFG_SMOOTHING_GAIN: gain_reg        <= cfg_data[15:0];
                    default: ;
                endcase
            end
            walk_pend_reg <= (cmd.op == OP_WALK);
            if (hist_we) begin
                hvld_reg[pix_reg] <= 1'b1;
                if (total_reg != TOTAL_MAX) begin
                    total_reg <= total_reg + 1'b1;
                end
            end
            if (cmd.op == OP_WALK_LAST) begin
                hvld_reg  <= '0;
                total_reg <= '0;
            end
            if (cmd.op == OP_ADD) begin
                if (cmd.sel_white) begin
                    sw_reg <= s_new;
                end else begin
                    sb_reg <= s_new;
                end
            end
            if (cmd.op == OP_RDIV_INIT) begin
                tblack_reg      <= bnew_reg;
                twhite_reg      <= wnew_reg;
                tbl_written_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (hist_re) begin
            hvld_q_reg <= hvld_reg[hist_raddr];
        end
        if (cmd.op == OP_PIX_RD) begin
            pix_reg     <= s_pixel;
            counted_reg <= s_counted;
        end
        if (cmd.op == OP_DIV_INIT) begin
            quo_reg   <= TOTAL_BITS'(pct_prod[60:RECIP_SHIFT]);
            acc_reg   <= '0;
            black_reg <= 8'd0;
            white_reg <= 8'd255;
        end
        if (cmd.op == OP_WALK) begin
            walk_idx_reg <= cmd.idx;
        end
        if (walk_pend_reg) begin
            acc_reg <= acc_sum;
            if (acc_sum <= ACC_W'(lo_val)) begin
                black_reg <= walk_idx_reg;
            end
            if (acc_sum <= ACC_W'(hi_val)) begin
                white_reg <= walk_idx_reg;
            end
        end
        if (cmd.op == OP_MUL) begin
            prod_reg <= 43'($signed({1'b0, gain_reg}) * diff);
        end
        if (cmd.op == OP_LEVEL) begin
            bnew_reg <= bnew8;
            wnew_reg <= w8;
        end
        if (cmd.op == OP_RDIV_INIT) begin
            rdvd_reg <= 8'hFF;
            rrem_reg <= '0;
            qd_reg   <= '0;
        end
        if (cmd.op == OP_RDIV_STEP) begin
            rdvd_reg <= rdvd_reg << 1;
            if (rdiv_r2 >= {1'b0, dd}) begin
                rrem_reg <= 8'(rdiv_r2 - {1'b0, dd});
                qd_reg   <= {qd_reg[6:0], 1'b1};
            end else begin
                rrem_reg <= rdiv_r2[7:0];
                qd_reg   <= {qd_reg[6:0], 1'b0};
            end
        end
        if (cmd.op == OP_BUILD) begin
            if (cmd.idx <= bnew_reg) begin
                qacc_reg <= '0;
                racc_reg <= '0;
            end else begin
                qacc_reg <= qn;
                racc_reg <= carry ? 8'(rr - {1'b0, dd}) : rr[7:0];
            end
        end
        if (cmd.out_load) begin
            m_colour_reg <= (cmd.op == OP_PIX_WR) ? pix_colour : 16'd0;
            m_black_reg  <= tblack_reg;
            m_white_reg  <= twhite_reg;
            m_upd_reg    <= cmd.upd;
            m_reb_reg    <= cmd.reb;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_colour         = m_colour_reg;
    assign m_black_point    = m_black_reg;
    assign m_white_point    = m_white_reg;
    assign m_levels_updated = m_upd_reg;
    assign m_table_rebuilt  = m_reb_reg;

endmodule

// File: rtl/core/hal_ctrl.sv
module hal_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_action,
    input  hal_pkg::hal_sts_t sts,
    output hal_pkg::hal_cmd_t cmd
);
    import hal_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PIX, ST_FE_CHK, ST_WALK, ST_WALK_END,
        ST_MUL_B, ST_ADD_B, ST_MUL_W, ST_ADD_W, ST_LEVEL, ST_CHG,
        ST_RDIV, ST_BUILD, ST_FE_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [8:0] cnt_reg, cnt_next;
    logic       upd_reg, upd_next, reb_reg, reb_next;

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        upd_next      = upd_reg;
        reb_next      = reb_reg;
        s_ready       = 1'b0;
        cmd.op        = OP_NONE;
        cmd.idx       = cnt_reg[7:0];
        cmd.sel_white = 1'b0;
        cmd.out_load  = 1'b0;
        cmd.upd       = upd_reg;
        cmd.reb       = reb_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_action) begin
                        state_next = ST_FE_CHK;
                    end else begin
                        cmd.op     = OP_PIX_RD;
                        state_next = ST_PIX;
                    end
                end
            end
            ST_PIX: begin
                cmd.upd = 1'b0;
                cmd.reb = 1'b0;
                if (sts.out_free) begin
                    cmd.op       = OP_PIX_WR;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_FE_CHK: begin
                upd_next = 1'b0;
                reb_next = 1'b0;
                cnt_next = '0;
                if (sts.enough) begin
                    cmd.op     = OP_DIV_INIT;
                    state_next = ST_WALK;
                end else begin
                    state_next = ST_FE_OUT;
                end
            end
            ST_WALK: begin
                cmd.op   = OP_WALK;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 9'd255) begin
                    state_next = ST_WALK_END;
                end
            end
            ST_WALK_END: begin
                cmd.op     = OP_WALK_LAST;
                state_next = ST_MUL_B;
            end
            ST_MUL_B: begin
                cmd.op     = OP_MUL;
                state_next = ST_ADD_B;
            end
            ST_ADD_B: begin
                cmd.op     = OP_ADD;
                state_next = ST_MUL_W;
            end
            ST_MUL_W: begin
                cmd.op        = OP_MUL;
                cmd.sel_white = 1'b1;
                state_next    = ST_ADD_W;
            end
            ST_ADD_W: begin
                cmd.op        = OP_ADD;
                cmd.sel_white = 1'b1;
                state_next    = ST_LEVEL;
            end
            ST_LEVEL: begin
                cmd.op     = OP_LEVEL;
                state_next = ST_CHG;
            end
            ST_CHG: begin
                upd_next = 1'b1;
                cnt_next = '0;
                if (sts.changed) begin
                    cmd.op     = OP_RDIV_INIT;
                    reb_next   = 1'b1;
                    state_next = ST_RDIV;
                end else begin
                    state_next = ST_FE_OUT;
                end
            end
            ST_RDIV: begin
                cmd.op = OP_RDIV_STEP;
                if (cnt_reg == 9'd7) begin
                    cnt_next   = '0;
                    state_next = ST_BUILD;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_BUILD: begin
                cmd.op   = OP_BUILD;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 9'd255) begin
                    state_next = ST_FE_OUT;
                end
            end
            ST_FE_OUT: begin
                if (sts.out_free) begin
                    cmd.op       = OP_FE_OUT;
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            upd_reg   <= 1'b0;
            reb_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            upd_reg   <= upd_next;
            reb_reg   <= reb_next;
        end
    end

endmodule

// File: rtl/core/histogram_auto_levels.sv
// Grey-to-colour mapper with histogram auto levels. Each accepted word with
// action 0 maps its pixel through the 256-entry colour table to byte-swapped
// RGB565 and, when counted is set, adds one to that pixel's histogram bin and
// to the sample total (both saturate). A pixel word first does the registered
// reads of the histogram and table memories, then, once the output register
// is free, the histogram write-back and the result. A frame-end word (action
// 1) with auto levels enabled and at least min_samples samples runs the level
// update: a check of the total that takes the percentile thresholds by a
// reciprocal multiply, a walk of the 256 histogram bins through the single
// read port, Q8.16 smoothing and level rounding, and, when a table level
// changes, a division for the per-entry step of 255 / span and a rewrite of
// the table one entry per cycle. Histogram entries carry per-bin valid flags,
// so reset and the frame-end clear take no sweep; the colour table reads as
// the grey ramp until its first rebuild. Results wait in an output register;
// configuration writes are to be made only while idle, which the block itself
// does not enforce.
module histogram_auto_levels #(
    parameter int BIN_BITS   = 16,
    parameter int TOTAL_BITS = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [hal_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hal_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_action,
    input  logic [7:0]                     s_pixel,
    input  logic                           s_counted,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [15:0]                    m_colour,
    output logic [7:0]                     m_black_point,
    output logic [7:0]                     m_white_point,
    output logic                           m_levels_updated,
    output logic                           m_table_rebuilt
);
    import hal_pkg::*;

    // Commands from the sequencer and status back from the datapath.
    hal_cmd_t cmd;
    hal_sts_t sts;

    hal_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_action(s_action),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath owns the configuration registers, both memories, the
    // smoothing arithmetic and the output word register.
    hal_datapath #(.BIN_BITS(BIN_BITS), .TOTAL_BITS(TOTAL_BITS)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_pixel         (s_pixel),
        .s_counted       (s_counted),
        .cmd             (cmd),
        .sts             (sts),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_colour        (m_colour),
        .m_black_point   (m_black_point),
        .m_white_point   (m_white_point),
        .m_levels_updated(m_levels_updated),
        .m_table_rebuilt (m_table_rebuilt)
    );

endmodule

// File: rtl/core/hal_checker.sv
`include "histogram_auto_levels_assert.svh"

module hal_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_we,
    input logic [2:0]  cfg_index,
    input logic [19:0] cfg_data,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_action,
    input logic [7:0]  s_pixel,
    input logic        s_counted,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_colour,
    input logic [7:0]  m_black_point,
    input logic [7:0]  m_white_point,
    input logic        m_levels_updated,
    input logic        m_table_rebuilt
);

    `HAL_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_colour))
    `HAL_ASSERT_NOW(a_rebuild_needs_update, aclk, aresetn, m_valid && m_table_rebuilt, m_levels_updated)
    `HAL_ASSERT_NOW(a_update_no_colour, aclk, aresetn, m_valid && m_levels_updated, m_colour == 16'd0)
    `HAL_ASSERT_NOW(a_levels_ordered, aclk, aresetn, m_valid, m_white_point >= m_black_point)

endmodule

bind histogram_auto_levels hal_checker u_hal_checker (.*);

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Testbench for histogram_auto_levels. A scoreboard model of the mapper keeps
// its own histogram, sample total, smoothed levels and colour lookup. Every
// accepted input word is run through that model, and the result word it
// should produce is queued. The checker process compares each accepted
// result word with the oldest queued prediction, field by field.
module tb_top;
    import hal_pkg::*;

    typedef struct {
        logic [15:0] colour;
        logic [7:0]  black_point;
        logic [7:0]  white_point;
        logic        levels_updated;
        logic        table_rebuilt;
    } result_word_t;

    localparam int SETTLE_CYCLES = 700;
    localparam int TARGET_WORDS  = 750;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_action;
    logic [7:0]            s_pixel;
    logic                  s_counted;
    logic                  m_valid;
    logic                  m_ready;
    logic [15:0]           m_colour;
    logic [7:0]            m_black_point;
    logic [7:0]            m_white_point;
    logic                  m_levels_updated;
    logic                  m_table_rebuilt;

    histogram_auto_levels DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_pixel(s_pixel), .s_counted(s_counted),
        .m_valid(m_valid), .m_ready(m_ready), .m_colour(m_colour),
        .m_black_point(m_black_point), .m_white_point(m_white_point),
        .m_levels_updated(m_levels_updated), .m_table_rebuilt(m_table_rebuilt)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Model copy of the configuration registers.
    logic        auto_on;
    logic [19:0] needed_samples;
    logic [7:0]  black_cap;
    logic [7:0]  white_min;
    logic [7:0]  span_min;
    logic [15:0] gain;

    // Model copy of the block state.
    int unsigned bin_count [256];
    int unsigned samples_seen;
    longint      level_black_q;
    longint      level_white_q;
    int          lut_black;
    int          lut_white;
    logic [15:0] colour_lut [256];

    result_word_t pending_results[$];

    int  error_count;
    int  words_sent;
    int  results_seen;
    int  updates_seen;
    int  rebuilds_seen;
    bit  idle_on;
    int  hold_cycles;

    function automatic logic [15:0] grey_to_rgb565(input int grey);
        logic [7:0]  g;
        logic [15:0] c;
        g = grey[7:0];
        c = (16'(g & 8'hf8) << 8) | (16'(g & 8'hfc) << 3) | 16'(g >> 3);
        return {c[7:0], c[15:8]};
    endfunction

    function automatic void rebuild_lut(input int b, input int w);
        int o;
        for (int v = 0; v < 256; v++) begin
            if (w <= b) begin
                o = (v < b) ? 0 : 255;
            end else if (v <= b) begin
                o = 0;
            end else begin
                o = (v - b) * 255 / (w - b);
                if (o > 255) o = 255;
            end
            colour_lut[v] = grey_to_rgb565(o);
        end
        lut_black = b & 255;
        lut_white = w & 255;
    endfunction

    // Moves a Q8.16 level toward the measured one; the arithmetic shift of
    // the signed product gives the floor, so halves round up.
    function automatic longint smooth_level(input longint s, input int measured);
        longint diff;
        longint r;
        diff = longint'(measured) * 65536 - s;
        r = s + ((longint'(gain) * diff + 32768) >>> 16);
        if (r < 0) r = 0;
        if (r > 255 * 65536) r = 255 * 65536;
        return r;
    endfunction

    function automatic void model_reset();
        auto_on        = 1'b1;
        needed_samples = 20'd2000;
        black_cap      = 8'd48;
        white_min      = 8'd160;
        span_min       = 8'd160;
        gain           = 16'd9830;
        foreach (bin_count[i]) bin_count[i] = 0;
        samples_seen  = 0;
        level_black_q = 0;
        level_white_q = 255 * 65536;
        rebuild_lut(0, 255);
    endfunction

    // Frame end with auto on and enough samples: percentile search, clear, smoothing and table update.
    function automatic void frame_update(output logic upd, output logic reb);
        longint acc;
        longint lo;
        longint hi;
        int     black;
        int     white;
        int     b;
        int     w;
        upd = 1'b0;
        reb = 1'b0;
        if (!auto_on || samples_seen < needed_samples) return;
        upd   = 1'b1;
        acc   = 0;
        black = 0;
        white = 255;
        lo    = samples_seen / 100;
        hi    = samples_seen - samples_seen / 200;
        for (int v = 0; v < 256; v++) begin
            acc += bin_count[v];
            if (acc <= lo) black = v;
            if (acc <= hi) white = v;
        end
        foreach (bin_count[i]) bin_count[i] = 0;
        samples_seen = 0;
        if (black > black_cap) black = black_cap;
        if (white < white_min) white = white_min;
        level_black_q = smooth_level(level_black_q, black);
        level_white_q = smooth_level(level_white_q, white);
        b = int'((level_black_q + 32768) / 65536);
        w = int'((level_white_q + 32768) / 65536);
        if (w - b < int'(span_min)) b = w - int'(span_min);
        if (b < 0) b = 0;
        if (b != lut_black || w != lut_white) begin
            rebuild_lut(b, w);
            reb = 1'b1;
        end
    endfunction

    function automatic result_word_t predict_word(input logic action, input logic [7:0] pixel,
                                                  input logic counted);
        result_word_t r;
        r.colour         = 16'd0;
        r.levels_updated = 1'b0;
        r.table_rebuilt  = 1'b0;
        if (!action) begin
            r.colour = colour_lut[pixel];
            if (counted) begin
                if (bin_count[pixel] < 32'hffff) bin_count[pixel]++;
                if (samples_seen < 32'hfffff) samples_seen++;
            end
        end else begin
            frame_update(r.levels_updated, r.table_rebuilt);
        end
        r.black_point = lut_black[7:0];
        r.white_point = lut_white[7:0];
        return r;
    endfunction

    // Sends one word. Valid stays high between back-to-back words, so this task
    // lowers it only when a gap is drawn.
    task automatic send_word(input logic action, input logic [7:0] pixel, input logic counted);
        int gap;
        gap = idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_action  <= action;
        s_pixel   <= pixel;
        s_counted <= counted;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_word(action, pixel, counted));
        words_sent++;
    endtask

    task automatic send_pixel(input int pixel, input logic counted);
        send_word(1'b0, pixel[7:0], counted);
    endtask

    task automatic send_frame_end();
        send_word(1'b1, 8'($urandom), 1'($urandom));
    endtask

    // Lowers valid, waits until every predicted word has arrived, then waits out
    // the SETTLE_CYCLES settle delay.
    task automatic wait_idle();
        @(posedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_AUTO_ENABLE:    auto_on        = value[0];
            CFG_MIN_SAMPLES:    needed_samples = value[19:0];
            CFG_BLACK_LIMIT:    black_cap      = value[7:0];
            CFG_WHITE_FLOOR:    white_min      = value[7:0];
            CFG_MIN_SPAN:       span_min       = value[7:0];
            CFG_SMOOTHING_GAIN: gain           = value[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int unsigned en, input int unsigned ms, input int unsigned bl,
                             input int unsigned wf, input int unsigned sp, input int unsigned gn);
        write_reg(CFG_AUTO_ENABLE, en);
        write_reg(CFG_MIN_SAMPLES, ms);
        write_reg(CFG_BLACK_LIMIT, bl);
        write_reg(CFG_WHITE_FLOOR, wf);
        write_reg(CFG_MIN_SPAN, sp);
        write_reg(CFG_SMOOTHING_GAIN, gn);
    endtask

    // One frame of pixels drawn from a grey band, then its frame end.
    task automatic send_frame(input int npix, input int lo_pix, input int hi_pix,
                              input int pct_counted);
        for (int i = 0; i < npix; i++)
            send_pixel($urandom_range(lo_pix, hi_pix), $urandom_range(0, 99) < pct_counted);
        send_frame_end();
    endtask

    // Receiver: draws a stall per word, or serves a requested long hold-off.
    initial begin
        m_ready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            int stall;
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = idle_on ? $urandom_range(0, 17) : 0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_word_t w;
            results_seen++;
            if (pending_results.size() == 0) begin
                $display("%0t: result word with nothing expected: colour %h", $time, m_colour);
                error_count++;
            end else begin
                w = pending_results.pop_front();
                if (w.levels_updated) updates_seen++;
                if (w.table_rebuilt) rebuilds_seen++;
                if (m_colour !== w.colour) begin
                    $display("%0t: colour expected %h actual %h", $time, w.colour, m_colour);
                    error_count++;
                end
                if (m_black_point !== w.black_point) begin
                    $display("%0t: black_point expected %0d actual %0d", $time,
                             w.black_point, m_black_point);
                    error_count++;
                end
                if (m_white_point !== w.white_point) begin
                    $display("%0t: white_point expected %0d actual %0d", $time,
                             w.white_point, m_white_point);
                    error_count++;
                end
                if (m_levels_updated !== w.levels_updated) begin
                    $display("%0t: levels_updated expected %b actual %b", $time,
                             w.levels_updated, m_levels_updated);
                    error_count++;
                end
                if (m_table_rebuilt !== w.table_rebuilt) begin
                    $display("%0t: table_rebuilt expected %b actual %b", $time,
                             w.table_rebuilt, m_table_rebuilt);
                    error_count++;
                end
            end
        end
    end

    // Right after reset the lookup is the grey ramp; extreme pixels, the
    // counted flag both ways, and a frame end with too few samples.
    task automatic test_reset_ramp();
        send_pixel(0, 1'b1);
        send_pixel(255, 1'b1);
        send_pixel(128, 1'b0);
        send_pixel(8'haa, 1'b1);
        send_pixel(8'h55, 1'b0);
        send_frame_end();
        send_pixel(255, 1'b0);
        wait_idle();
    endtask

    // Register extremes: zero threshold on the histogram left from the reset test,
    // auto disabled, indexes past the register list, full and zero gain, zero span.
    task automatic test_register_extremes();
        write_all(1, 0, 255, 0, 255, 65535);
        send_frame_end();
        send_pixel(200, 1'b1);
        wait_idle();
        write_reg(3'd6, 20'hfffff);
        write_reg(3'd7, 20'h12345);
        write_all(0, 0, 0, 255, 1, 0);
        send_frame(6, 0, 255, 100);
        wait_idle();
        // Zero span and a frame of grey value 90, then uncounted pixels 89 and 90.
        write_all(1, 3, 255, 0, 0, 65535);
        send_frame(12, 90, 90, 100);
        send_pixel(89, 1'b0);
        send_pixel(90, 1'b0);
        wait_idle();
        write_all(1, 20'hfffff, 0, 255, 1, 32768);
        send_frame(4, 0, 255, 100);
        wait_idle();
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_backpressure();
        write_all(1, 10, 60, 150, 100, 40000);
        idle_on = 1'b0;
        hold_cycles = 400;
        send_frame(40, 20, 230, 90);
        idle_on = 1'b1;
        send_frame(30, 0, 255, 90);
        wait_idle();
    endtask

    // Random frames across random register settings, with the sender
    // pausing for an empty pipeline now and then.
    task automatic test_random_frames();
        int frame_no;
        frame_no = 0;
        while (words_sent < TARGET_WORDS) begin
            if (frame_no % 6 == 0) begin
                wait_idle();
                write_all(($urandom_range(0, 9) != 0),
                          ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20'hfffff)
                                                      : $urandom_range(0, 40),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255),
                          ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535));
            end else if (frame_no % 6 == 3) begin
                @(posedge aclk);
                s_valid <= 1'b0;
                while (pending_results.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            idle_on = ($urandom_range(0, 4) != 0);
            begin
                int lo_pix;
                int hi_pix;
                lo_pix = $urandom_range(0, 255);
                hi_pix = $urandom_range(lo_pix, 255);
                if ($urandom_range(0, 3) == 0) begin
                    lo_pix = 0;
                    hi_pix = 255;
                end
                send_frame($urandom_range(5, 45), lo_pix, hi_pix, $urandom_range(60, 100));
            end
            frame_no++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        error_count   = 0;
        words_sent    = 0;
        results_seen  = 0;
        updates_seen  = 0;
        rebuilds_seen = 0;
        idle_on       = 1'b1;
        hold_cycles   = 0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_action      = 1'b0;
        s_pixel       = 8'd0;
        s_counted     = 1'b0;
        model_reset();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_ramp();
        test_register_extremes();
        test_output_backpressure();
        test_random_frames();

        wait_idle();
        $display("Sent %0d words and checked %0d results, %0d level updates, %0d rebuilds.",
                 words_sent, results_seen, updates_seen, rebuilds_seen);
        $display("Covered register extremes, stalls on both sides and a long output hold-off.");
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
